@@ rtl/nfa_pkg.sv @@
// shared constants and control/status types for the next-fit id allocator
`default_nettype none

package nfa_pkg;

  // id pool
  localparam int unsigned MAX_ID   = 1023;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ST_W     = 2;

  // used map organized as rows of bits
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BIT_W    = $clog2(WORD_W);
  localparam int unsigned WORD_CNT = (MAX_ID + 1) / WORD_W;
  localparam int unsigned ADDR_W   = $clog2(WORD_CNT);
  localparam int unsigned CNT_W    = $clog2(MAX_ID + 1);

  // stream payload widths
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 16;

  // op codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NO    = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic rd_scan;
    logic rd_item;
    logic scan_step;
    logic commit;
    logic set_res;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic is_lookup;
    logic in_range;
    logic pool_full;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/next_fit_id_allocator_top.sv @@
// Next-fit id allocator: hands out ids 1..1023, frees and looks them up.
// Input stream: one item per request, op (allocate, release, query) and id.
// Output stream: exactly one item per request, result id and status.
// The used map sits in a 32-row by 32-bit memory with one valid bit per row;
// an allocate reads one row per cycle from the row of the id after the last
// grant and priority-encodes the first free bit, wrapping past the top id to 1.
// Release and query go through the decide, item and done states; an allocate
// goes through decide, one scan step per row read (1 to 33) and done, the
// shortest when the row of the id after the last grant has room. A full pool,
// an id out of range or an unknown op goes from decide straight to done. The
// row scan sets the pace: one item at a time, none taken before the last is
// through; the next item is accepted once the previous result is in the output
// register, so a waiting result does not hold off the next request.
// When the receiver stalls, the finished result waits in the result register
// until the output register frees, and the input is held off meanwhile.
// Reset clears every row valid bit, the last grant and the use count at once,
// so all ids are free and the block takes items on the first cycle after it.
`default_nettype none

module next_fit_id_allocator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] op, [11:2] id, [15:12] zero
  input  wire logic [nfa_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [9:0] result_id, [11:10] status, [15:12] zero
  output logic      [nfa_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import nfa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  nfa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // map, search and output
  nfa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

`default_nettype wire

@@ rtl/nfa_ctrl.sv @@
// sequencing state machine of the id allocator
`default_nettype none

module nfa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire nfa_pkg::stat_t stat_i,
  output nfa_pkg::cmd_t      cmd_o
);
  import nfa_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECIDE    = 3'd1;
  localparam logic [2:0] S_EVAL_SCAN = 3'd2;
  localparam logic [2:0] S_EVAL_ITEM = 3'd3;
  localparam logic [2:0] S_DONE      = 3'd4;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.is_alloc && !stat_i.pool_full) begin
          cmd_o.rd_scan = 1'b1;
          state_d       = S_EVAL_SCAN;
        end else if (stat_i.is_lookup && stat_i.in_range) begin
          cmd_o.rd_item = 1'b1;
          state_d       = S_EVAL_ITEM;
        end else begin
          cmd_o.set_res = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_EVAL_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.commit  = 1'b1;
          cmd_o.set_res = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
          cmd_o.rd_scan   = 1'b1;
        end
      end
      S_EVAL_ITEM: begin
        cmd_o.commit  = 1'b1;
        cmd_o.set_res = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/nfa_dp.sv @@
// used-map memory, search logic, counters and output register of the id allocator
`default_nettype none

module nfa_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [nfa_pkg::S_DATA_W-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [nfa_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input  wire nfa_pkg::cmd_t                  cmd_i,
  output nfa_pkg::stat_t                      stat_o
);
  import nfa_pkg::*;

  // used map rows, a row not yet written reads as all free
  logic [WORD_W-1:0]   used_mem [WORD_CNT];
  logic [WORD_CNT-1:0] row_vld_q;
  logic [WORD_W-1:0]   rd_data_q;
  logic [ADDR_W-1:0]   rd_addr_q;

  logic [OP_W-1:0]     op_q;
  logic [ID_W-1:0]     id_q;
  logic [ID_W-1:0]     last_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [ADDR_W-1:0]   scan_addr_q;
  logic                first_q;
  logic [ID_W-1:0]     res_id_q;
  logic [ST_W-1:0]     res_st_q;
  logic                m_vld_q;
  logic [M_DATA_W-1:0] m_data_q;

  logic [ID_W-1:0]     start_id;
  logic [ADDR_W-1:0]   scan_addr_d;
  logic [ADDR_W-1:0]   rd_addr;
  logic [WORD_W-1:0]   word_val;
  logic [WORD_W-1:0]   free_vec;
  logic [BIT_W-1:0]    pos;
  logic                hit;
  logic [BIT_W-1:0]    item_bit_idx;
  logic                item_bit;
  logic                is_alloc, is_rel, is_query, in_range, pool_full;
  logic                wr_en;
  logic [WORD_W-1:0]   wr_data;
  logic [ID_W-1:0]     res_id_d;
  logic [ST_W-1:0]     res_st_d;

  // item decode
  assign is_alloc  = (op_q == OP_ALLOC);
  assign is_rel    = (op_q == OP_RELEASE);
  assign is_query  = (op_q == OP_QUERY);
  assign in_range  = (id_q != '0) && ({1'b0, id_q} <= (ID_W + 1)'(MAX_ID));
  assign pool_full = (cnt_q >= CNT_W'(MAX_ID));

  // search starts just after the last granted id, wrapping to 1
  assign start_id = (last_q >= ID_W'(MAX_ID)) ? ID_W'(1) : last_q + ID_W'(1);

  // read address: next scan row or the row of the item id
  assign scan_addr_d = cmd_i.scan_step ? scan_addr_q + ADDR_W'(1) : scan_addr_q;
  assign rd_addr     = cmd_i.rd_item ? id_q[ID_W-1:BIT_W] : scan_addr_d;

  // row under evaluation
  assign word_val = row_vld_q[rd_addr_q] ? rd_data_q : '0;

  // free bits, skipping ids below the start on the first row and id zero
  always_comb begin
    free_vec = ~word_val;
    if (first_q) begin
      free_vec = free_vec & ({WORD_W{1'b1}} << start_id[BIT_W-1:0]);
    end
    if (rd_addr_q == '0) begin
      free_vec[0] = 1'b0;
    end
  end

  // lowest free bit
  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        pos = BIT_W'(i);
      end
    end
  end
  assign hit = |free_vec;

  assign item_bit_idx = id_q[BIT_W-1:0];
  assign item_bit     = word_val[item_bit_idx];

  // write back on grant or on release of a used id
  assign wr_en   = cmd_i.commit && (is_alloc || (is_rel && item_bit));
  assign wr_data = is_alloc ? (word_val | (WORD_W'(1) << pos))
                            : (word_val & ~(WORD_W'(1) << item_bit_idx));

  // result of the item
  always_comb begin
    res_id_d = id_q;
    res_st_d = ST_RANGE;
    if (is_alloc) begin
      if (pool_full) begin
        res_id_d = '0;
        res_st_d = ST_NO;
      end else begin
        res_id_d = {rd_addr_q, pos};
        res_st_d = ST_OK;
      end
    end else if ((is_rel || is_query) && in_range) begin
      res_st_d = item_bit ? ST_OK : ST_NO;
    end
  end

  // memory port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      used_mem[rd_addr_q] <= wr_data;
    end
    if (cmd_i.rd_scan || cmd_i.rd_item) begin
      rd_data_q <= used_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q <= s_axis_tdata[OP_W-1:0];
      id_q <= s_axis_tdata[OP_W+ID_W-1:OP_W];
    end
    if (cmd_i.rd_scan || cmd_i.rd_item) begin
      rd_addr_q <= rd_addr;
    end
    if (cmd_i.set_res) begin
      res_id_q <= res_id_d;
      res_st_q <= res_st_d;
    end
    if (cmd_i.out_load) begin
      m_data_q <= M_DATA_W'({res_st_q, res_id_q});
    end
  end

  // scan position
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      scan_addr_q <= start_id[ID_W-1:BIT_W];
      first_q     <= 1'b1;
    end else if (cmd_i.scan_step) begin
      scan_addr_q <= scan_addr_d;
      first_q     <= 1'b0;
    end
  end

  // control state: row valid bits, last grant, use count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      last_q    <= '0;
      cnt_q     <= '0;
      m_vld_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[rd_addr_q] <= 1'b1;
        if (is_alloc) begin
          last_q <= {rd_addr_q, pos};
          cnt_q  <= cnt_q + CNT_W'(1);
        end else begin
          cnt_q  <= cnt_q - CNT_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

  // status to the controller
  assign stat_o.is_alloc  = is_alloc;
  assign stat_o.is_lookup = is_rel || is_query;
  assign stat_o.in_range  = in_range;
  assign stat_o.pool_full = pool_full;
  assign stat_o.hit       = hit;
  assign stat_o.out_free  = !m_vld_q || m_axis_tready;

endmodule

`default_nettype wire

@@ rtl/nfa_checker.sv @@
// port-level checks for the id allocator, bound to the top level
`default_nettype none

module nfa_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [nfa_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import nfa_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: input closes right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item accepted while busy");

  // status is always a defined code and padding is zero
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[ID_W+ST_W-1:ID_W] == ST_OK ||
                       m_axis_tdata[ID_W+ST_W-1:ID_W] == ST_NO ||
                       m_axis_tdata[ID_W+ST_W-1:ID_W] == ST_RANGE) &&
                      m_axis_tdata[M_DATA_W-1:ID_W+ST_W] == '0)
    else $error("bad status code or padding");

  // an ok result never carries id zero
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[ID_W+ST_W-1:ID_W] == ST_OK
      |-> m_axis_tdata[ID_W-1:0] != '0)
    else $error("ok status with id zero");

endmodule

bind next_fit_id_allocator_top nfa_checker u_nfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
